// ----- hw/rtl/mesi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesi_pkg
// Shared types, codes and the microcode program of the MESI line controller.
// ----------------------------------------------------------------------------
package mesi_pkg;

  localparam int DATA_W = 32;
  localparam int ST_W   = 2;
  localparam int WORD_W = ST_W + DATA_W;

  localparam logic [DATA_W-1:0] MEM_RESET = 32'd15213;

  // Operation codes carried in the request.
  localparam logic [1:0] K_READ  = 2'd0;
  localparam logic [1:0] K_WRITE = 2'd1;
  localparam logic [1:0] K_EVICT = 2'd2;
  localparam logic [1:0] K_NONE  = 2'd3;

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_E = 2'd2,
    ST_M = 2'd3
  } line_st_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_RD_OWN,
    OP_LATCH_OWN,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_FILL,
    OP_SHARE,
    OP_HIT,
    OP_WR_OWN,
    OP_DROP_OWN,
    OP_PROMOTE,
    OP_EMIT
  } uop_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_START,
    C_BAD,
    C_WRITE,
    C_EVICT,
    C_OWN_VALID,
    C_SCAN_MORE,
    C_FOUND,
    C_OWN_EXCL,
    C_OWN_SHARED,
    C_ONE_LEFT,
    C_CLR_MORE,
    C_OUT_FREE
  } cond_t;

  typedef logic [4:0] upc_t;

  typedef struct packed {
    uop_t op;
    cond_t cond;
    upc_t  jump_true;
    upc_t  jump_false;
  } ucode_t;

  // Status flags that the datapath hands to the sequencer.
  typedef struct packed {
    logic start;
    logic bad;
    logic is_write;
    logic is_evict;
    logic own_valid;
    logic scan_more;
    logic found;
    logic own_excl;
    logic own_shared;
    logic one_left;
    logic clr_more;
    logic out_free;
  } seq_flags_t;

  localparam upc_t U_CLR  = 5'd0;
  localparam upc_t U_IDLE = 5'd1;
  localparam upc_t U_RHIT = 5'd12;
  localparam upc_t U_WR   = 5'd13;
  localparam upc_t U_EV   = 5'd17;
  localparam upc_t U_OUT  = 5'd23;

  function automatic ucode_t ucode_rom(input upc_t a);
    ucode_t u;
    case (a)
      5'd0:  u = '{OP_CLEAR,     C_CLR_MORE,   U_CLR,  U_IDLE};
      5'd1:  u = '{OP_LOAD,      C_START,      5'd2,   U_IDLE};
      5'd2:  u = '{OP_RD_OWN,    C_BAD,        U_OUT,  5'd3};
      5'd3:  u = '{OP_LATCH_OWN, C_ALWAYS,     5'd4,   5'd4};
      5'd4:  u = '{OP_NOP,       C_WRITE,      U_WR,   5'd5};
      5'd5:  u = '{OP_NOP,       C_EVICT,      U_EV,   5'd6};
      // Read.
      5'd6:  u = '{OP_NOP,       C_OWN_VALID,  U_RHIT, 5'd7};
      5'd7:  u = '{OP_SCAN_INIT, C_ALWAYS,     5'd8,   5'd8};
      5'd8:  u = '{OP_SCAN,      C_SCAN_MORE,  5'd8,   5'd9};
      5'd9:  u = '{OP_NOP,       C_FOUND,      5'd11,  5'd10};
      5'd10: u = '{OP_FILL,      C_ALWAYS,     U_OUT,  U_OUT};
      5'd11: u = '{OP_SHARE,     C_ALWAYS,     U_OUT,  U_OUT};
      5'd12: u = '{OP_HIT,       C_ALWAYS,     U_OUT,  U_OUT};
      // Write.
      5'd13: u = '{OP_NOP,       C_OWN_EXCL,   5'd16,  5'd14};
      5'd14: u = '{OP_SCAN_INIT, C_ALWAYS,     5'd15,  5'd15};
      5'd15: u = '{OP_SCAN,      C_SCAN_MORE,  5'd15,  5'd16};
      5'd16: u = '{OP_WR_OWN,    C_ALWAYS,     U_OUT,  U_OUT};
      // Evict.
      5'd17: u = '{OP_NOP,       C_OWN_VALID,  5'd18,  U_OUT};
      5'd18: u = '{OP_DROP_OWN,  C_OWN_SHARED, 5'd19,  U_OUT};
      5'd19: u = '{OP_SCAN_INIT, C_ALWAYS,     5'd20,  5'd20};
      5'd20: u = '{OP_SCAN,      C_SCAN_MORE,  5'd20,  5'd21};
      5'd21: u = '{OP_NOP,       C_ONE_LEFT,   5'd22,  U_OUT};
      5'd22: u = '{OP_PROMOTE,   C_ALWAYS,     U_OUT,  U_OUT};
      5'd23: u = '{OP_EMIT,      C_OUT_FREE,   U_IDLE, U_OUT};
      default: u = '{OP_NOP,     C_ALWAYS,     U_IDLE, U_IDLE};
    endcase
    return u;
  endfunction

endpackage

// ----- hw/rtl/mesi_single_line_coherence_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesi_single_line_coherence_unit
// MESI state and data for one memory line across NUM_CORES cores.
// ----------------------------------------------------------------------------
//   Each request on the in_ channel is a read, write or evict by one core and
//   produces exactly one result on the out_ channel (read data and a related
//   flag). Requests are handled one at a time by a microcoded sequencer, and
//   per-core state and data live in one RAM with a registered read port.
//   A read miss scans the cores through the single read port, one core per
//   cycle, and stops at the first other holder; a write to an S/I line or an
//   evict of a Shared line scans every core. A read hit, a write to an E/M
//   line, an evict of an Invalid line and an ignored request need no scan.
//   in_tready rises together with out_tvalid, once the result is registered.
//   The result sits in an output register, so the next request is accepted
//   while it waits for out_tready; if the receiver stalls longer, the
//   following result waits inside and in_tready stays low. After reset a
//   clearing pass sets every line Invalid with in_tready low.
// ----------------------------------------------------------------------------
module mesi_single_line_coherence_unit #(
  parameter int NUM_CORES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [3:0] core_id, [35:4] write_data, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] read_data, [32] related, rest zero
);

  localparam int AW = $clog2(NUM_CORES);
  localparam int JW = $clog2(NUM_CORES + 1);
  localparam int DW = mesi_pkg::DATA_W;
  localparam int WW = mesi_pkg::WORD_W;

  mesi_pkg::uop_t       op;
  mesi_pkg::seq_flags_t flags;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  logic [1:0]    kind_r, kind_nxt;
  logic [3:0]    core_r, core_nxt;
  logic [DW-1:0] wdata_r, wdata_nxt;
  logic [DW-1:0] mem_r, mem_nxt;
  logic [1:0]    own_st_r, own_st_nxt;
  logic [DW-1:0] own_d_r, own_d_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic          pv_r, pv_nxt;
  logic [AW-1:0] pj_r, pj_nxt;
  logic          found_r, found_nxt;
  logic [DW-1:0] sd_r, sd_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [DW-1:0] last_d_r, last_d_nxt;
  logic [DW-1:0] rd_r, rd_nxt;
  logic          rel_r, rel_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_rd_r, out_rd_nxt;
  logic          out_rel_r, out_rel_nxt;

  logic [AW-1:0] core_a;
  logic [1:0]    scan_st;
  logic [DW-1:0] scan_d;
  logic          scan_other;
  logic          issue;
  logic          stop_now;
  logic          out_free;

  assign core_a     = AW'(core_r);
  assign scan_st    = ram_rdata[WW-1:DW];
  assign scan_d     = ram_rdata[DW-1:0];
  assign scan_other = pv_r && (pj_r != core_a);
  assign issue      = (j_r != JW'(NUM_CORES));
  assign out_free   = !out_valid_r || out_tready;
  // A read miss stops at the first other holder.
  assign stop_now   = (kind_r == mesi_pkg::K_READ) && scan_other &&
                      (scan_st != mesi_pkg::ST_I) && !found_r;

  assign in_tready  = (op == mesi_pkg::OP_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_rel_r, out_rd_r};

  always_comb begin
    flags.start      = in_tvalid;
    flags.bad        = (kind_r == mesi_pkg::K_NONE) ||
                       ({28'd0, core_r} >= 32'(NUM_CORES));
    flags.is_write   = (kind_r == mesi_pkg::K_WRITE);
    flags.is_evict   = (kind_r == mesi_pkg::K_EVICT);
    flags.own_valid  = (own_st_r != mesi_pkg::ST_I);
    flags.scan_more  = issue && !stop_now;
    flags.found      = found_r;
    flags.own_excl   = (own_st_r == mesi_pkg::ST_M) || (own_st_r == mesi_pkg::ST_E);
    flags.own_shared = (own_st_r == mesi_pkg::ST_S);
    flags.one_left   = (cnt_r == 2'd1);
    flags.clr_more   = (j_r != JW'(NUM_CORES - 1));
    flags.out_free   = out_free;
  end

  mesi_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .op    (op)
  );

  mesi_ram #(
    .WIDTH (WW),
    .DEPTH (NUM_CORES)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    kind_nxt      = kind_r;
    core_nxt      = core_r;
    wdata_nxt     = wdata_r;
    mem_nxt       = mem_r;
    own_st_nxt    = own_st_r;
    own_d_nxt     = own_d_r;
    j_nxt         = j_r;
    pv_nxt        = pv_r;
    pj_nxt        = pj_r;
    found_nxt     = found_r;
    sd_nxt        = sd_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    last_d_nxt    = last_d_r;
    rd_nxt        = rd_r;
    rel_nxt       = rel_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_rd_nxt    = out_rd_r;
    out_rel_nxt   = out_rel_r;
    ram_we        = 1'b0;
    ram_waddr     = core_a;
    ram_wdata     = '0;
    ram_raddr     = core_a;

    case (op)
      mesi_pkg::OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[AW-1:0];
        ram_wdata = {mesi_pkg::ST_I, {DW{1'b0}}};
        j_nxt     = j_r + 1'b1;
      end
      mesi_pkg::OP_LOAD: begin
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          core_nxt  = in_tdata[3:0];
          wdata_nxt = in_tdata[35:4];
          rd_nxt    = '0;
          rel_nxt   = 1'b0;
        end
      end
      mesi_pkg::OP_RD_OWN: begin
        ram_raddr = core_a;
      end
      mesi_pkg::OP_LATCH_OWN: begin
        own_st_nxt = ram_rdata[WW-1:DW];
        own_d_nxt  = ram_rdata[DW-1:0];
      end
      mesi_pkg::OP_SCAN_INIT: begin
        j_nxt     = '0;
        pv_nxt    = 1'b0;
        found_nxt = 1'b0;
        cnt_nxt   = 2'd0;
      end
      mesi_pkg::OP_SCAN: begin
        // Issue the next core's read while the previous one is examined.
        ram_raddr = j_r[AW-1:0];
        pv_nxt    = issue;
        pj_nxt    = j_r[AW-1:0];
        if (issue) begin
          j_nxt = j_r + 1'b1;
        end
        ram_waddr = pj_r;
        case (kind_r)
          mesi_pkg::K_READ: begin
            if (stop_now) begin
              found_nxt = 1'b1;
              sd_nxt    = scan_d;
              if (scan_st == mesi_pkg::ST_M) begin
                mem_nxt = scan_d;
              end
              ram_we    = 1'b1;
              ram_wdata = {mesi_pkg::ST_S, scan_d};
            end
          end
          mesi_pkg::K_WRITE: begin
            if (scan_other) begin
              if (scan_st == mesi_pkg::ST_M) begin
                mem_nxt = scan_d;
              end
              ram_we    = 1'b1;
              ram_wdata = {mesi_pkg::ST_I, {DW{1'b0}}};
            end
          end
          mesi_pkg::K_EVICT: begin
            if (scan_other && (scan_st == mesi_pkg::ST_S)) begin
              cnt_nxt    = (cnt_r == 2'd0) ? 2'd1 : 2'd2;
              last_nxt   = pj_r;
              last_d_nxt = scan_d;
            end
          end
          default: begin
          end
        endcase
      end
      mesi_pkg::OP_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {mesi_pkg::ST_E, mem_r};
        rd_nxt    = mem_r;
        rel_nxt   = 1'b1;
      end
      mesi_pkg::OP_SHARE: begin
        ram_we    = 1'b1;
        ram_wdata = {mesi_pkg::ST_S, sd_r};
        rd_nxt    = sd_r;
        rel_nxt   = 1'b1;
      end
      mesi_pkg::OP_HIT: begin
        rd_nxt  = own_d_r;
        rel_nxt = 1'b1;
      end
      mesi_pkg::OP_WR_OWN: begin
        ram_we    = 1'b1;
        ram_wdata = {mesi_pkg::ST_M, wdata_r};
        rel_nxt   = 1'b1;
      end
      mesi_pkg::OP_DROP_OWN: begin
        ram_we    = 1'b1;
        ram_wdata = {mesi_pkg::ST_I, {DW{1'b0}}};
        if (own_st_r == mesi_pkg::ST_M) begin
          mem_nxt = own_d_r;
        end
        rel_nxt = 1'b1;
      end
      mesi_pkg::OP_PROMOTE: begin
        ram_we    = 1'b1;
        ram_waddr = last_r;
        ram_wdata = {mesi_pkg::ST_E, last_d_r};
      end
      mesi_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rd_r;
          out_rel_nxt   = rel_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_r       <= mesi_pkg::MEM_RESET;
      j_r         <= '0;
      pv_r        <= 1'b0;
      found_r     <= 1'b0;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      mem_r       <= mem_nxt;
      j_r         <= j_nxt;
      pv_r        <= pv_nxt;
      found_r     <= found_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    core_r    <= core_nxt;
    wdata_r   <= wdata_nxt;
    own_st_r  <= own_st_nxt;
    own_d_r   <= own_d_nxt;
    pj_r      <= pj_nxt;
    sd_r      <= sd_nxt;
    last_r    <= last_nxt;
    last_d_r  <= last_d_nxt;
    rd_r      <= rd_nxt;
    rel_r     <= rel_nxt;
    out_rd_r  <= out_rd_nxt;
    out_rel_r <= out_rel_nxt;
  end

endmodule

// ----- hw/rtl/mesi_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesi_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mesi_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/mesi_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesi_seq
// Microprogram sequencer: step counter, control store and branch selection.
// ----------------------------------------------------------------------------
module mesi_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  mesi_pkg::seq_flags_t flags,
  output mesi_pkg::uop_t      op
);

  mesi_pkg::upc_t   upc_r;
  mesi_pkg::upc_t   upc_nxt;
  mesi_pkg::ucode_t word;
  logic             taken;

  assign word = mesi_pkg::ucode_rom(upc_r);

  always_comb begin
    case (word.cond)
      mesi_pkg::C_ALWAYS:     taken = 1'b1;
      mesi_pkg::C_START:      taken = flags.start;
      mesi_pkg::C_BAD:        taken = flags.bad;
      mesi_pkg::C_WRITE:      taken = flags.is_write;
      mesi_pkg::C_EVICT:      taken = flags.is_evict;
      mesi_pkg::C_OWN_VALID:  taken = flags.own_valid;
      mesi_pkg::C_SCAN_MORE:  taken = flags.scan_more;
      mesi_pkg::C_FOUND:      taken = flags.found;
      mesi_pkg::C_OWN_EXCL:   taken = flags.own_excl;
      mesi_pkg::C_OWN_SHARED: taken = flags.own_shared;
      mesi_pkg::C_ONE_LEFT:   taken = flags.one_left;
      mesi_pkg::C_CLR_MORE:   taken = flags.clr_more;
      mesi_pkg::C_OUT_FREE:   taken = flags.out_free;
      default:                taken = 1'b1;
    endcase
    upc_nxt = taken ? word.jump_true : word.jump_false;
  end

  always_comb begin
    op = word.op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= mesi_pkg::U_CLR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule
